### src/iftfc_pkg.sv
// Shared types and constants for the IPv4 five-tuple flow counter.
package iftfc_pkg;

  // Result status codes.
  localparam logic [2:0] ST_UPDATED   = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_DISABLED  = 3'd3;
  localparam logic [2:0] ST_NOT_IPV4  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;

  // Header byte offsets and protocol constants.
  localparam int unsigned ETYPE_HI   = 12;
  localparam int unsigned ETYPE_LO   = 13;
  localparam int unsigned IHL_POS    = 14;
  localparam int unsigned PROTO_POS  = 23;
  localparam int unsigned SADDR_POS  = 26;
  localparam int unsigned DADDR_POS  = 30;
  localparam int unsigned ETH_MIN    = 14;
  localparam int unsigned IPV4_MIN   = 34;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [7:0]  TCP_NEED   = 8'd20;
  localparam logic [7:0]  UDP_NEED   = 8'd8;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] frame_length;
    logic [63:0] timestamp;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] entry_index;
    logic [63:0] packet_count;
    logic [63:0] byte_count;
    logic [63:0] seen_time;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  protocol;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  pr;
  } tuple_t;

  typedef struct packed {
    tuple_t      key;
    logic [63:0] pkts;
    logic [63:0] bytes;
    logic [63:0] seen;
  } flow_row_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic check;
    logic search;
    logic settle;
    logic commit;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic parse_ok;
    logic hit;
    logic miss;
    logic out_free;
  } dp_stat_t;

endpackage

### src/iftfc_ctrl.sv
// Controller state machine for the flow counter.
module iftfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  input  iftfc_pkg::dp_stat_t st,
  output iftfc_pkg::ctl_cmd_t cmd,
  output logic               in_stall
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = st.parse_ok ? S_SEARCH : S_COMMIT;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (st.hit || st.miss) begin
          cmd.settle = 1'b1;
          state_nxt  = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Checks.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !cmd.accept) else $error("beat taken while busy");
  a_check_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |=> state_r == S_SEARCH || state_r == S_COMMIT)
    else $error("check state lingered");
  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_IDLE) else $error("commit did not end the frame");

endmodule

### src/iftfc_dp.sv
// Datapath: header capture, parse, flow table memory and result register.
module iftfc_dp #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned HEADER_BYTES  = 96
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iftfc_pkg::in_beat_t  in_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  iftfc_pkg::ctl_cmd_t  cmd,
  output iftfc_pkg::dp_stat_t  st,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iftfc_pkg::out_beat_t out_data
);

  localparam int unsigned PW = $clog2(HEADER_BYTES + 1);
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);

  logic [PW-1:0] pos_r, vis_r;
  logic          enable_r;
  logic [15:0]   etype_r;
  logic [3:0]    ihl_r;
  logic [7:0]    proto_r;
  logic [31:0]   sa_r, da_r;
  logic [15:0]   sp_r, dp_r;
  logic [15:0]   len_r;
  logic [63:0]   ts_r;

  iftfc_pkg::tuple_t    key_r, key_nxt;
  iftfc_pkg::flow_row_t mem [TABLE_ENTRIES];
  iftfc_pkg::flow_row_t rd_row_r, wr_row_r;
  logic [UW-1:0]        used_r, scan_r;
  logic [IW-1:0]        cmp_idx_r, slot_r;
  logic                 cmp_vld_r, wr_r, ins_r;
  logic [2:0]           pre_status, res_status_r;
  logic                 out_valid_r;
  iftfc_pkg::out_beat_t out_r;

  // Port offset: at byte 14 the IHL nibble is still on the input.
  logic [3:0]    ihl_cur;
  logic [6:0]    off_cur;
  logic [PW-1:0] port_rel;
  assign ihl_cur  = (pos_r == PW'(iftfc_pkg::IHL_POS)) ? in_data.data_byte[3:0] : ihl_r;
  assign off_cur  = 7'd14 + {1'b0, ihl_cur, 2'b00};
  assign port_rel = pos_r - PW'(off_cur);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      enable_r <= cfg_wr_data;
    end
  end

  // Byte position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.accept) begin
      if (in_data.last_byte) begin
        pos_r <= '0;
      end else if (pos_r < PW'(HEADER_BYTES)) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  // Header field capture and visible length as bytes stream by.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (in_data.last_byte) begin
        vis_r <= (pos_r < PW'(HEADER_BYTES)) ? pos_r + 1'b1 : PW'(HEADER_BYTES);
        len_r <= in_data.frame_length;
        ts_r  <= in_data.timestamp;
      end
      if (pos_r == PW'(iftfc_pkg::ETYPE_HI)) etype_r[15:8] <= in_data.data_byte;
      if (pos_r == PW'(iftfc_pkg::ETYPE_LO)) etype_r[7:0]  <= in_data.data_byte;
      if (pos_r == PW'(iftfc_pkg::IHL_POS))  ihl_r         <= in_data.data_byte[3:0];
      if (pos_r == PW'(iftfc_pkg::PROTO_POS)) proto_r      <= in_data.data_byte;
      if (pos_r == PW'(iftfc_pkg::SADDR_POS))     sa_r[31:24] <= in_data.data_byte;
      if (pos_r == PW'(iftfc_pkg::SADDR_POS + 1)) sa_r[23:16] <= in_data.data_byte;
      if (pos_r == PW'(iftfc_pkg::SADDR_POS + 2)) sa_r[15:8]  <= in_data.data_byte;
      if (pos_r == PW'(iftfc_pkg::SADDR_POS + 3)) sa_r[7:0]   <= in_data.data_byte;
      if (pos_r == PW'(iftfc_pkg::DADDR_POS))     da_r[31:24] <= in_data.data_byte;
      if (pos_r == PW'(iftfc_pkg::DADDR_POS + 1)) da_r[23:16] <= in_data.data_byte;
      if (pos_r == PW'(iftfc_pkg::DADDR_POS + 2)) da_r[15:8]  <= in_data.data_byte;
      if (pos_r == PW'(iftfc_pkg::DADDR_POS + 3)) da_r[7:0]   <= in_data.data_byte;
      if (pos_r >= PW'(off_cur) && port_rel < PW'(4)) begin
        case (port_rel[1:0])
          2'd0:    sp_r[15:8] <= in_data.data_byte;
          2'd1:    sp_r[7:0]  <= in_data.data_byte;
          2'd2:    dp_r[15:8] <= in_data.data_byte;
          default: dp_r[7:0]  <= in_data.data_byte;
        endcase
      end
    end
  end

  // Parse of the captured header.
  logic [7:0] off_chk, need;
  logic       ports_ok;
  always_comb begin
    off_chk = 8'd14 + {2'b00, ihl_r, 2'b00};
    if (proto_r == iftfc_pkg::PROTO_TCP) begin
      need = iftfc_pkg::TCP_NEED;
    end else if (proto_r == iftfc_pkg::PROTO_UDP) begin
      need = iftfc_pkg::UDP_NEED;
    end else begin
      need = 8'd0;
    end
    ports_ok = (need != 8'd0) && ({1'b0, off_chk} + {1'b0, need} <= 9'(vis_r));
    key_nxt.sa = sa_r;
    key_nxt.da = da_r;
    key_nxt.pr = proto_r;
    key_nxt.sp = ports_ok ? sp_r : 16'd0;
    key_nxt.dp = ports_ok ? dp_r : 16'd0;
    if (!enable_r) begin
      pre_status = iftfc_pkg::ST_DISABLED;
    end else if (vis_r < PW'(iftfc_pkg::ETH_MIN)) begin
      pre_status = iftfc_pkg::ST_TRUNCATED;
    end else if (etype_r != iftfc_pkg::ETYPE_IPV4) begin
      pre_status = iftfc_pkg::ST_NOT_IPV4;
    end else if (vis_r < PW'(iftfc_pkg::IPV4_MIN)) begin
      pre_status = iftfc_pkg::ST_TRUNCATED;
    end else begin
      pre_status = iftfc_pkg::ST_UPDATED;
    end
  end

  assign st.parse_ok = (pre_status == iftfc_pkg::ST_UPDATED);
  assign st.hit      = cmd.search && cmp_vld_r && (rd_row_r.key == key_r);
  assign st.miss     = cmd.search && !cmp_vld_r && (scan_r == used_r);
  assign st.out_free = !out_valid_r || !out_stall;

  // Table walk: one row read per cycle, compared the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else if (cmd.check) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.search && !st.hit && (scan_r < used_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      scan_r <= '0;
      key_r  <= key_nxt;
    end else if (cmd.search && scan_r < used_r) begin
      rd_row_r  <= mem[scan_r[IW-1:0]];
      cmp_idx_r <= scan_r[IW-1:0];
      scan_r    <= scan_r + 1'b1;
    end
  end

  // Outcome of the frame: new row contents and status.
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res_status_r <= pre_status;
      wr_r         <= 1'b0;
      ins_r        <= 1'b0;
      slot_r       <= '0;
      wr_row_r     <= '0;
    end else if (cmd.settle) begin
      wr_row_r.key  <= key_r;
      wr_row_r.seen <= ts_r;
      if (st.hit) begin
        res_status_r   <= iftfc_pkg::ST_UPDATED;
        slot_r         <= cmp_idx_r;
        wr_r           <= 1'b1;
        wr_row_r.pkts  <= rd_row_r.pkts + 64'd1;
        wr_row_r.bytes <= rd_row_r.bytes + {48'd0, len_r};
      end else if (used_r < UW'(TABLE_ENTRIES)) begin
        res_status_r   <= iftfc_pkg::ST_INSERTED;
        slot_r         <= used_r[IW-1:0];
        wr_r           <= 1'b1;
        ins_r          <= 1'b1;
        wr_row_r.pkts  <= 64'd1;
        wr_row_r.bytes <= {48'd0, len_r};
      end else begin
        res_status_r <= iftfc_pkg::ST_FULL;
      end
    end
  end

  // Memory write and fill count.
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_r) begin
      mem[slot_r] <= wr_row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.commit && ins_r) begin
      used_r <= used_r + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  logic shown;
  assign shown = (res_status_r == iftfc_pkg::ST_UPDATED) ||
                 (res_status_r == iftfc_pkg::ST_INSERTED) ||
                 (res_status_r == iftfc_pkg::ST_FULL);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.status              <= res_status_r;
      out_r.entry_index         <= 12'(slot_r);
      out_r.packet_count        <= wr_r ? wr_row_r.pkts : 64'd0;
      out_r.byte_count          <= wr_r ? wr_row_r.bytes : 64'd0;
      out_r.seen_time           <= wr_r ? wr_row_r.seen : 64'd0;
      out_r.source_address      <= shown ? key_r.sa : 32'd0;
      out_r.destination_address <= shown ? key_r.da : 32'd0;
      out_r.source_port         <= shown ? key_r.sp : 16'd0;
      out_r.destination_port    <= shown ? key_r.dp : 16'd0;
      out_r.protocol            <= shown ? key_r.pr : 8'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_ENTRIES)) else $error("fill count past table size");
  a_hit_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    st.hit |-> UW'(cmp_idx_r) < used_r) else $error("hit on unused slot");
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && ins_r |=> used_r == $past(used_r) + 1'b1)
    else $error("insert did not grow the table");

endmodule

### src/ipv4_five_tuple_flow_counter.sv
// Top level of the IPv4 five-tuple flow counter.
// Frame bytes are taken one per cycle on the input channel, while intake is not
// held for a frame end. On the last beat of a frame the block parses the captured
// Ethernet/IPv4/TCP/UDP header and, when enabled and the header holds a complete
// IPv4 frame, walks the flow table one slot per cycle from slot 0 over the slots
// in use. A frame end holds intake through a check step and a commit step; for a
// counted frame the walk lies between them, reading each slot and comparing it
// once read, until the flow is found or the miss is declared after the last slot
// in use. The commit also waits while the previous result beat is still held.
// Each frame gives one result beat, held in an output register until taken.
// Table slots fill in order and are never freed, so no clearing pass is needed
// after reset.
module ipv4_five_tuple_flow_counter #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned HEADER_BYTES  = 96
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iftfc_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iftfc_pkg::out_beat_t out_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data
);

  iftfc_pkg::ctl_cmd_t cmd;
  iftfc_pkg::dp_stat_t st;

  iftfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_byte),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  iftfc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

### verif/tb.sv
// Self-checking testbench for the IPv4 five-tuple flow counter.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SLOTS = 4096;
  localparam int unsigned HDR_KEEP = 96;
  localparam int unsigned WATCH_LIMIT = 40000;

  // Flow accounting predictor and the queue of expected result beats.
  class flow_scoreboard;
    logic [7:0]           hdr[HDR_KEEP];
    int unsigned          pos;
    iftfc_pkg::tuple_t    keys[SLOTS];
    logic [63:0]          pkts[SLOTS];
    logic [63:0]          bytes[SLOTS];
    logic [63:0]          seen[SLOTS];
    int unsigned          used;
    bit                   enabled;
    iftfc_pkg::out_beat_t pending[$];
    int unsigned          errors;
    int unsigned          frames;
    int unsigned          counts[6];

    function new();
      pos = 0;
      used = 0;
      enabled = 0;
      errors = 0;
      frames = 0;
    endfunction

    function logic [7:0] hbyte(int unsigned i);
      return (i < HDR_KEEP) ? hdr[i] : 8'h00;
    endfunction

    // Apply one accepted input beat to the predicted state.
    function void note_input(iftfc_pkg::in_beat_t b);
      iftfc_pkg::out_beat_t r;
      iftfc_pkg::tuple_t    k;
      int unsigned          vis;
      int unsigned          off;
      int unsigned          need;
      int                   hit;
      logic [7:0]           ihl_b;
      if (pos < HDR_KEEP) begin
        hdr[pos] = b.data_byte;
        pos++;
      end
      if (!b.last_byte) return;
      vis = pos;
      pos = 0;
      r = '0;
      frames++;
      if (!enabled) r.status = iftfc_pkg::ST_DISABLED;
      else if (vis < iftfc_pkg::ETH_MIN) r.status = iftfc_pkg::ST_TRUNCATED;
      else if ({hbyte(iftfc_pkg::ETYPE_HI), hbyte(iftfc_pkg::ETYPE_LO)} !=
               iftfc_pkg::ETYPE_IPV4) r.status = iftfc_pkg::ST_NOT_IPV4;
      else if (vis < iftfc_pkg::IPV4_MIN) r.status = iftfc_pkg::ST_TRUNCATED;
      else begin
        k = '0;
        k.sa = {hbyte(26), hbyte(27), hbyte(28), hbyte(29)};
        k.da = {hbyte(30), hbyte(31), hbyte(32), hbyte(33)};
        k.pr = hbyte(iftfc_pkg::PROTO_POS);
        ihl_b = hbyte(iftfc_pkg::IHL_POS);
        off = 14 + 4 * ihl_b[3:0];
        need = (k.pr == iftfc_pkg::PROTO_TCP) ? 20 : (k.pr == iftfc_pkg::PROTO_UDP) ? 8 : 0;
        if (need != 0 && off + need <= vis) begin
          k.sp = {hbyte(off), hbyte(off + 1)};
          k.dp = {hbyte(off + 2), hbyte(off + 3)};
        end
        r.source_address = k.sa;
        r.destination_address = k.da;
        r.source_port = k.sp;
        r.destination_port = k.dp;
        r.protocol = k.pr;
        hit = -1;
        for (int i = 0; i < used; i++)
          if (keys[i] == k) begin
            hit = i;
            break;
          end
        if (hit >= 0) begin
          pkts[hit] += 1;
          bytes[hit] += b.frame_length;
          seen[hit] = b.timestamp;
          r.status = iftfc_pkg::ST_UPDATED;
        end else if (used < SLOTS) begin
          hit = used;
          used++;
          keys[hit] = k;
          pkts[hit] = 1;
          bytes[hit] = b.frame_length;
          seen[hit] = b.timestamp;
          r.status = iftfc_pkg::ST_INSERTED;
        end else r.status = iftfc_pkg::ST_FULL;
        if (hit >= 0) begin
          r.entry_index = hit[11:0];
          r.packet_count = pkts[hit];
          r.byte_count = bytes[hit];
          r.seen_time = seen[hit];
        end
      end
      counts[r.status]++;
      pending.push_back(r);
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(iftfc_pkg::out_beat_t got);
      iftfc_pkg::out_beat_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        $display("%0t: status exp %0d got %0d", $realtime, e.status, got.status);
      if (got.entry_index !== e.entry_index)
        $display("%0t: entry_index exp %0d got %0d", $realtime, e.entry_index,
                 got.entry_index);
      if (got.packet_count !== e.packet_count)
        $display("%0t: packet_count exp %0d got %0d", $realtime, e.packet_count,
                 got.packet_count);
      if (got.byte_count !== e.byte_count)
        $display("%0t: byte_count exp %0d got %0d", $realtime, e.byte_count,
                 got.byte_count);
      if (got.seen_time !== e.seen_time)
        $display("%0t: seen_time exp %h got %h", $realtime, e.seen_time, got.seen_time);
      if (got.source_address !== e.source_address)
        $display("%0t: source_address exp %h got %h", $realtime, e.source_address,
                 got.source_address);
      if (got.destination_address !== e.destination_address)
        $display("%0t: destination_address exp %h got %h", $realtime,
                 e.destination_address, got.destination_address);
      if (got.source_port !== e.source_port)
        $display("%0t: source_port exp %h got %h", $realtime, e.source_port,
                 got.source_port);
      if (got.destination_port !== e.destination_port)
        $display("%0t: destination_port exp %h got %h", $realtime, e.destination_port,
                 got.destination_port);
      if (got.protocol !== e.protocol)
        $display("%0t: protocol exp %0d got %0d", $realtime, e.protocol, got.protocol);
      if (got !== e) errors++;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  iftfc_pkg::in_beat_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  iftfc_pkg::out_beat_t out_data;
  logic                 cfg_wr_en = 1'b0;
  logic                 cfg_wr_data = 1'b0;

  flow_scoreboard sb = new();
  bit          idle_on = 1'b1;
  bit          hold_rx = 1'b0;
  int unsigned quiet = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  logic [7:0]  frame[$];
  // Small pool of flows so that lookups hit often.
  logic [31:0] pool_sa[8];
  logic [31:0] pool_da[8];
  logic [15:0] pool_port[8];

  always #10 clk = ~clk;

  ipv4_five_tuple_flow_counter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Sample both channels and run the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_input(in_data);
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
        beats_out++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else quiet++;
      if (quiet >= WATCH_LIMIT) begin
        $display("watchdog expired with %0d results pending", sb.pending.size());
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Receiver stall: random bursts, or a long hold-off when asked.
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk);
      if (hold_rx) out_stall <= 1'b1;
      else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else out_stall <= 1'b0;
    end
  end

  // Send one byte beat and wait for its acceptance.
  task automatic send_beat(logic [7:0] d, logic last, logic [15:0] len, logic [63:0] ts);
    int unsigned n;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: d, last_byte: last, frame_length: len, timestamp: ts};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Send the queued frame bytes, the last one marked.
  task automatic send_frame(logic [15:0] len, logic [63:0] ts);
    for (int i = 0; i < frame.size(); i++)
      send_beat(frame[i], i == frame.size() - 1, len, ts);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    // A frame still in its table walk can give no more result.
    repeat (SLOTS + 20) @(negedge clk);
  endtask

  task automatic set_enable(bit v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.enabled = v;
  endtask

  // Build an IPv4 frame of the given visible size around a chosen flow.
  task automatic build_ipv4(int unsigned nbytes, logic [7:0] proto, logic [3:0] ihl,
                            logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                            logic [15:0] dp);
    int unsigned off;
    frame.delete();
    for (int i = 0; i < nbytes; i++) frame.push_back(8'($urandom_range(0, 255)));
    off = 14 + 4 * ihl;
    if (nbytes > 13) begin
      frame[12] = 8'h08;
      frame[13] = 8'h00;
    end
    if (nbytes > 14) frame[14] = {4'($urandom_range(0, 15)), ihl};
    if (nbytes > 23) frame[23] = proto;
    for (int i = 0; i < 4; i++) begin
      if (26 + i < nbytes) frame[26 + i] = sa[31 - 8 * i -: 8];
      if (30 + i < nbytes) frame[30 + i] = da[31 - 8 * i -: 8];
    end
    if (off + 3 < nbytes) begin
      frame[off] = sp[15:8];
      frame[off + 1] = sp[7:0];
      frame[off + 2] = dp[15:8];
      frame[off + 3] = dp[7:0];
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_frame();
    int unsigned r;
    int unsigned f;
    int unsigned nb;
    logic [7:0]  pr;
    r = $urandom_range(0, 99);
    f = $urandom_range(0, 7);
    pr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
         ($urandom_range(0, 1) ? iftfc_pkg::PROTO_TCP : iftfc_pkg::PROTO_UDP);
    nb = ($urandom_range(0, 9) == 0) ? $urandom_range(97, 130) : $urandom_range(34, 70);
    if (r < 75)
      build_ipv4(nb, pr, ($urandom_range(0, 5) == 0) ? 4'($urandom()) : 4'd5,
                 pool_sa[f], pool_da[f], pool_port[f], pool_port[7 - f]);
    else if (r < 90)
      build_ipv4(nb, pr, 4'($urandom()), $urandom(), $urandom(), 16'($urandom()),
                 16'($urandom()));
    else begin
      // Noise: random bytes, often short.
      frame.delete();
      nb = $urandom_range(1, 40);
      for (int i = 0; i < nb; i++) frame.push_back(8'($urandom_range(0, 255)));
    end
    send_frame(($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom()),
               ($urandom_range(0, 9) == 0) ? 64'hffff_ffff_ffff_ffff : rand64());
  endtask

  initial begin
    int unsigned n;
    for (int i = 0; i < 8; i++) begin
      pool_sa[i] = $urandom();
      pool_da[i] = $urandom();
      pool_port[i] = 16'($urandom());
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Disabled after reset: frames pass uncounted.
    build_ipv4(40, iftfc_pkg::PROTO_UDP, 4'd5, pool_sa[0], pool_da[0], 16'd1, 16'd2);
    send_frame(16'd40, 64'd5);
    wait_drained();
    set_enable(1'b1);

    // Directed: short Ethernet, wrong ethertype, short IPv4, port cases.
    frame.delete();
    frame.push_back(8'hff);
    send_frame(16'd0, 64'd0);
    frame.delete();
    for (int i = 0; i < 20; i++) frame.push_back(8'hff);
    send_frame(16'hffff, 64'hffff_ffff_ffff_ffff);
    build_ipv4(33, iftfc_pkg::PROTO_TCP, 4'd5, 32'hffff_ffff, 32'h0, 16'h0, 16'hffff);
    send_frame(16'd33, 64'd1);
    build_ipv4(54, iftfc_pkg::PROTO_TCP, 4'd5, 32'hffff_ffff, 32'h0, 16'hffff, 16'h0);
    send_frame(16'hffff, 64'hffff_ffff_ffff_ffff);
    build_ipv4(54, iftfc_pkg::PROTO_TCP, 4'd5, 32'hffff_ffff, 32'h0, 16'hffff, 16'h0);
    send_frame(16'hffff, 64'd7);
    build_ipv4(53, iftfc_pkg::PROTO_TCP, 4'd5, 32'h1, 32'h2, 16'h3, 16'h4);
    send_frame(16'd53, 64'd8);
    build_ipv4(42, iftfc_pkg::PROTO_UDP, 4'd5, 32'h1, 32'h2, 16'h3, 16'h4);
    send_frame(16'd42, 64'd9);
    build_ipv4(41, iftfc_pkg::PROTO_UDP, 4'd5, 32'h1, 32'h2, 16'h3, 16'h4);
    send_frame(16'd41, 64'd10);
    build_ipv4(40, iftfc_pkg::PROTO_UDP, 4'd0, 32'h1, 32'h2, 16'h3, 16'h4);
    send_frame(16'd40, 64'd11);
    build_ipv4(96, iftfc_pkg::PROTO_UDP, 4'd15, 32'h1, 32'h2, 16'h3, 16'h4);
    send_frame(16'd120, 64'd12);
    build_ipv4(60, 8'd1, 4'd5, 32'h5, 32'h6, 16'h7, 16'h8);
    send_frame(16'd60, 64'd13);
    wait_drained();

    // Long receiver hold-off while frames keep coming.
    idle_on = 1'b0;
    hold_rx = 1'b1;
    fork
      begin
        n = 0;
        while (n < 400) begin
          @(negedge clk);
          n++;
        end
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 6; i++) random_frame();
    join
    idle_on = 1'b1;
    wait_drained();

    // Random traffic, a pause for drain and toggles of the enable midway.
    for (int i = 0; i < 10; i++) begin
      random_frame();
      if (i == 3) begin
        wait_drained();
        set_enable(1'b0);
      end
      if (i == 5) begin
        wait_drained();
        set_enable(1'b1);
      end
      if (i == 7) idle_on = 1'b0;
    end
    wait_drained();

    $display("frames %0d beats in %0d results %0d: updated %0d inserted %0d", sb.frames,
             beats_in, beats_out, sb.counts[iftfc_pkg::ST_UPDATED],
             sb.counts[iftfc_pkg::ST_INSERTED]);
    $display("disabled %0d not IPv4 %0d truncated %0d, flows in table %0d",
             sb.counts[iftfc_pkg::ST_DISABLED], sb.counts[iftfc_pkg::ST_NOT_IPV4],
             sb.counts[iftfc_pkg::ST_TRUNCATED], sb.used);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
